/* hdl/dtsf_pkg.sv */
// Package for the two-hit diagonal seed filter.
// Holds the shared constants, register indexes and types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtsf_pkg;

    localparam int POS_BITS      = 11;
    localparam int LEN_W         = POS_BITS + 1;
    localparam int MAX_DIAGONALS = 4096;
    localparam int ADDR_W        = $clog2(MAX_DIAGONALS);
    localparam int CALC_W        = (LEN_W > ADDR_W) ? LEN_W + 2 : ADDR_W + 2;
    localparam int GAP_W         = POS_BITS + 2;
    localparam int EPOCH_W       = 8;

    localparam int KMER_W   = 6;
    localparam int WINDOW_W = 11;
    localparam int QLEN_W   = 12;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [KMER_W-1:0]   KMER_RESET   = KMER_W'(12);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(40);
    localparam logic [QLEN_W-1:0]   QLEN_RESET   = QLEN_W'(2048);

    localparam logic [1:0] REG_KMER_LENGTH  = 2'd0;
    localparam logic [1:0] REG_PAIR_WINDOW  = 2'd1;
    localparam logic [1:0] REG_QUERY_LENGTH = 2'd2;

    localparam logic ACT_HIT   = 1'b0;
    localparam logic ACT_BEGIN = 1'b1;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

    typedef struct packed {
        logic [KMER_W-1:0]   kmer_length;
        logic [WINDOW_W-1:0] pair_window;
        logic [QLEN_W-1:0]   query_length;
    } cfg_t;

    typedef struct packed {
        logic [EPOCH_W-1:0]  epoch;
        logic                paired;
        logic [POS_BITS-1:0] last_tpos;
    } diag_entry_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } ctl_state_t;

endpackage

`default_nettype wire

/* hdl/diagonal_two_hit_seed_filter.sv */
// Top level of the two-hit diagonal seed filter.
// Depends on dtsf_pkg, dtsf_cfg_regs, dtsf_diag_table and dtsf_hit_eval.
//
// A seed hit is taken in every cycle while busy is low, and its result, if
// any, passes through the s1 stage registers and the output registers and
// shows on the seed ports with seed_valid high for one cycle; the receiver
// cannot stall it. Each hit does one read and at most one write of the
// 4096-entry diagonal memory, with forwarding between back-to-back hits
// on the same diagonal. A begin item advances the epoch and loads the
// target length: diagonals are retired by an 8-bit epoch mark stored with each entry.
// After reset, and on every 255th begin when the epoch wraps, the block runs
// a clearing pass over all 4096 entries with busy high; settings may still be
// written during that pass.
`timescale 1ns / 1ps
`default_nettype none

module diagonal_two_hit_seed_filter (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         action,
    input  wire logic [dtsf_pkg::POS_BITS-1:0] query_pos,
    input  wire logic [dtsf_pkg::POS_BITS-1:0] target_pos,
    input  wire logic [dtsf_pkg::LEN_W-1:0]    target_length,
    output logic                              seed_valid,
    output logic      [dtsf_pkg::POS_BITS-1:0] seed_query_pos,
    output logic      [dtsf_pkg::POS_BITS-1:0] seed_target_pos,
    output logic                              bad_diagonal,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dtsf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dtsf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dtsf_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    dtsf_pkg::cfg_t        cfg;
    dtsf_pkg::ctl_state_t  state_reg;
    dtsf_pkg::ctl_state_t  state_next;
    logic [dtsf_pkg::ADDR_W-1:0]  clr_addr_reg;
    logic [dtsf_pkg::ADDR_W-1:0]  clr_addr_next;
    logic [dtsf_pkg::EPOCH_W-1:0] epoch_reg;
    logic [dtsf_pkg::EPOCH_W-1:0] epoch_next;
    logic [dtsf_pkg::LEN_W-1:0]   ctl_reg;

    logic accept;
    logic accept_hit;
    logic accept_begin;

    logic signed [dtsf_pkg::CALC_W-1:0] diag;
    logic signed [dtsf_pkg::CALC_W-1:0] limit;
    logic                               diag_bad;

    logic                          s1_valid_reg;
    logic                          s1_bad_reg;
    logic [dtsf_pkg::ADDR_W-1:0]   s1_addr_reg;
    logic [dtsf_pkg::POS_BITS-1:0] s1_qpos_reg;
    logic [dtsf_pkg::POS_BITS-1:0] s1_tpos_reg;

    dtsf_pkg::diag_entry_t         rd_entry;
    dtsf_pkg::diag_entry_t         ev_entry;
    dtsf_pkg::diag_entry_t         wr_entry;
    logic                          ev_write;
    logic                          ev_emit;
    logic [dtsf_pkg::POS_BITS-1:0] ev_qpos;
    logic [dtsf_pkg::POS_BITS-1:0] ev_tpos;
    logic                          mem_wr_en;
    logic [dtsf_pkg::ADDR_W-1:0]   mem_wr_addr;

    logic                          out_valid_reg;
    logic [dtsf_pkg::POS_BITS-1:0] out_qpos_reg;
    logic [dtsf_pkg::POS_BITS-1:0] out_tpos_reg;
    logic                          out_bad_reg;

    dtsf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy         = (state_reg == dtsf_pkg::ST_CLEAR);
    assign accept       = start && !busy;
    assign accept_hit   = accept && (action == dtsf_pkg::ACT_HIT);
    assign accept_begin = accept && (action == dtsf_pkg::ACT_BEGIN);

    assign diag  = $signed(dtsf_pkg::CALC_W'(query_pos)) - $signed(dtsf_pkg::CALC_W'(target_pos))
                 + $signed(dtsf_pkg::CALC_W'(ctl_reg)) - $signed(dtsf_pkg::CALC_W'(1));
    assign limit = $signed(dtsf_pkg::CALC_W'(cfg.query_length)) - $signed(dtsf_pkg::CALC_W'(1))
                 + $signed(dtsf_pkg::CALC_W'(ctl_reg));
    assign diag_bad = (diag < 0) || (diag >= limit)
                   || (diag >= $signed(dtsf_pkg::CALC_W'(dtsf_pkg::MAX_DIAGONALS)));

    dtsf_diag_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (diag[dtsf_pkg::ADDR_W-1:0]),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (wr_entry),
        .rd_data (rd_entry)
    );

    dtsf_hit_eval u_eval (
        .cfg       (cfg),
        .epoch     (epoch_reg),
        .entry     (rd_entry),
        .qpos      (s1_qpos_reg),
        .tpos      (s1_tpos_reg),
        .do_write  (ev_write),
        .new_entry (ev_entry),
        .emit      (ev_emit),
        .seed_qpos (ev_qpos),
        .seed_tpos (ev_tpos)
    );

    always_comb
    begin
        if (busy)
        begin
            mem_wr_en       = 1'b1;
            mem_wr_addr     = clr_addr_reg;
            wr_entry.epoch  = '0;
            wr_entry.paired = 1'b0;
            wr_entry.last_tpos = '0;
        end
        else
        begin
            mem_wr_en   = s1_valid_reg && !s1_bad_reg && ev_write;
            mem_wr_addr = s1_addr_reg;
            wr_entry    = ev_entry;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        unique case (state_reg)
            dtsf_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + dtsf_pkg::ADDR_W'(1);
                if (clr_addr_reg == {dtsf_pkg::ADDR_W{1'b1}})
                begin
                    state_next = dtsf_pkg::ST_RUN;
                    epoch_next = dtsf_pkg::EPOCH_FIRST;
                end
            end
            dtsf_pkg::ST_RUN:
            begin
                if (accept_begin)
                begin
                    if (epoch_reg == dtsf_pkg::EPOCH_LAST)
                    begin
                        state_next    = dtsf_pkg::ST_CLEAR;
                        clr_addr_next = '0;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + dtsf_pkg::EPOCH_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = dtsf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtsf_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            epoch_reg     <= dtsf_pkg::EPOCH_FIRST;
            ctl_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            s1_valid_reg  <= accept_hit;
            out_valid_reg <= s1_valid_reg && (s1_bad_reg || ev_emit);
            if (accept_begin)
            begin
                ctl_reg <= target_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_bad_reg   <= diag_bad;
        s1_addr_reg  <= diag[dtsf_pkg::ADDR_W-1:0];
        s1_qpos_reg  <= query_pos;
        s1_tpos_reg  <= target_pos;
        out_bad_reg  <= s1_bad_reg;
        out_qpos_reg <= s1_bad_reg ? '0 : ev_qpos;
        out_tpos_reg <= s1_bad_reg ? '0 : ev_tpos;
    end

    assign seed_valid      = out_valid_reg;
    assign seed_query_pos  = out_qpos_reg;
    assign seed_target_pos = out_tpos_reg;
    assign bad_diagonal    = out_bad_reg;

endmodule

`default_nettype wire

/* hdl/dtsf_cfg_regs.sv */
// APB register file for the seed filter settings.
// Depends on dtsf_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dtsf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dtsf_pkg::PDATA_W-1:0] pwdata,
    output logic      [dtsf_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output dtsf_pkg::cfg_t                   cfg
);

    dtsf_pkg::cfg_t cfg_reg;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kmer_length  <= dtsf_pkg::KMER_RESET;
            cfg_reg.pair_window  <= dtsf_pkg::WINDOW_RESET;
            cfg_reg.query_length <= dtsf_pkg::QLEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                dtsf_pkg::REG_KMER_LENGTH:
                    cfg_reg.kmer_length <= pwdata[dtsf_pkg::KMER_W-1:0];
                dtsf_pkg::REG_PAIR_WINDOW:
                    cfg_reg.pair_window <= pwdata[dtsf_pkg::WINDOW_W-1:0];
                dtsf_pkg::REG_QUERY_LENGTH:
                    cfg_reg.query_length <= pwdata[dtsf_pkg::QLEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dtsf_pkg::REG_KMER_LENGTH:
                prdata = dtsf_pkg::PDATA_W'(cfg_reg.kmer_length);
            dtsf_pkg::REG_PAIR_WINDOW:
                prdata = dtsf_pkg::PDATA_W'(cfg_reg.pair_window);
            dtsf_pkg::REG_QUERY_LENGTH:
                prdata = dtsf_pkg::PDATA_W'(cfg_reg.query_length);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/dtsf_diag_table.sv */
// Diagonal table: one synchronous memory with a registered read port and
// write-to-read forwarding. Depends on dtsf_pkg for diag_entry_t.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_diag_table (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [dtsf_pkg::ADDR_W-1:0] rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [dtsf_pkg::ADDR_W-1:0] wr_addr,
    input  wire dtsf_pkg::diag_entry_t      wr_data,
    output dtsf_pkg::diag_entry_t           rd_data
);

    dtsf_pkg::diag_entry_t mem [dtsf_pkg::MAX_DIAGONALS];
    dtsf_pkg::diag_entry_t rd_data_reg;
    dtsf_pkg::diag_entry_t fwd_data_reg;
    logic                  fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

`default_nettype wire

/* hdl/dtsf_hit_eval.sv */
// Second-stage hit evaluation: overlap, pairing and midpoint seed.
// Depends on dtsf_pkg for widths, cfg_t and diag_entry_t.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_hit_eval (
    input  wire dtsf_pkg::cfg_t               cfg,
    input  wire logic [dtsf_pkg::EPOCH_W-1:0] epoch,
    input  wire dtsf_pkg::diag_entry_t        entry,
    input  wire logic [dtsf_pkg::POS_BITS-1:0] qpos,
    input  wire logic [dtsf_pkg::POS_BITS-1:0] tpos,
    output logic                              do_write,
    output dtsf_pkg::diag_entry_t             new_entry,
    output logic                              emit,
    output logic      [dtsf_pkg::POS_BITS-1:0] seed_qpos,
    output logic      [dtsf_pkg::POS_BITS-1:0] seed_tpos
);

    logic                               seen;
    logic signed [dtsf_pkg::GAP_W-1:0]  gap;
    logic signed [dtsf_pkg::GAP_W-1:0]  kmer_ext;
    logic signed [dtsf_pkg::GAP_W-1:0]  window_ext;
    logic signed [dtsf_pkg::GAP_W-1:0]  half;
    logic signed [dtsf_pkg::GAP_W-1:0]  q_diff;
    logic signed [dtsf_pkg::GAP_W-1:0]  t_diff;
    logic                               overlap;
    logic                               in_window;

    assign seen       = (entry.epoch == epoch);
    assign gap        = $signed(dtsf_pkg::GAP_W'(tpos))
                      - $signed(dtsf_pkg::GAP_W'(entry.last_tpos));
    assign kmer_ext   = $signed(dtsf_pkg::GAP_W'(cfg.kmer_length));
    assign window_ext = $signed(dtsf_pkg::GAP_W'(cfg.pair_window));
    assign overlap    = seen && (gap < kmer_ext);
    assign in_window  = (gap <= window_ext);
    assign half       = gap >>> 1;
    assign q_diff     = $signed(dtsf_pkg::GAP_W'(qpos)) - half;
    assign t_diff     = $signed(dtsf_pkg::GAP_W'(tpos)) - half;

    always_comb
    begin
        do_write            = !overlap;
        emit                = 1'b0;
        new_entry.epoch     = epoch;
        new_entry.last_tpos = tpos;
        new_entry.paired    = 1'b0;
        if (seen && in_window)
        begin
            new_entry.paired = 1'b1;
            emit             = !overlap && !entry.paired;
        end
        seed_qpos = q_diff[dtsf_pkg::GAP_W-1] ? '0 : q_diff[dtsf_pkg::POS_BITS-1:0];
        seed_tpos = t_diff[dtsf_pkg::GAP_W-1] ? '0 : t_diff[dtsf_pkg::POS_BITS-1:0];
    end

endmodule

`default_nettype wire
